// File: rtl/core/jsu_pkg.sv
// Shared types and character codes for the JSON string unescaper.
// No dependencies; imported by jsu_decode, jsu_burst and json_string_unescape.
package jsu_pkg;

  // One input byte causes at most six result beats (\ u d d d plus a byte)
  localparam int MaxBeats = 6;
  localparam int CntW     = $clog2(MaxBeats + 1);

  // Result beats produced by one input byte, entry 0 goes out first
  typedef struct packed {
    logic [MaxBeats-1:0][7:0] bytes;
    logic [MaxBeats-1:0]      err;
    logic [CntW-1:0]          count;
    logic                     last;
  } burst_t;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_N   = 8'h6e;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_F_HEX = 8'h66;

  localparam logic [7:0] HEX_CASE_MASK   = 8'hdf;
  localparam logic [7:0] HEX_LETTER_BIAS = 8'h37;  // '7'
  localparam logic [7:0] NIBBLE_MASK     = 8'h0f;

endpackage

// File: rtl/core/jsu_decode.sv
// Escape decoder: parse state plus the per-byte decode into a result burst.
// Depends on jsu_pkg.
module jsu_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output jsu_pkg::burst_t burst
);
  import jsu_pkg::*;

  typedef enum logic [1:0] {
    MODE_COPY = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_HEX  = 2'd2
  } mode_t;

  mode_t       mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] code_unit, code_unit_next;
  logic [7:0]  held [3];
  logic [7:0]  held_next [3];

  function automatic burst_t push(burst_t b, logic [7:0] v, logic e);
    b.bytes[b.count] = v;
    b.err[b.count]   = e;
    b.count          = b.count + CntW'(1);
    return b;
  endfunction

  logic       is_hex;
  logic [7:0] letter;
  logic [3:0] hex_val;
  logic [15:0] cu;
  logic [1:0]  replay_n;
  logic        do_replay;
  logic        do_plain;
  burst_t      b;

  assign is_hex = (in_byte >= CH_0 && in_byte <= CH_9) ||
                  (in_byte >= CH_UC_A && in_byte <= CH_UC_F) ||
                  (in_byte >= CH_LC_A && in_byte <= CH_LC_F_HEX);
  assign letter  = (in_byte & HEX_CASE_MASK) - HEX_LETTER_BIAS;
  assign hex_val = (in_byte >= CH_UC_A) ? letter[3:0] : in_byte[3:0];
  assign cu      = {code_unit[11:0], hex_val};

  always_comb begin
    b              = '0;
    mode_next      = MODE_COPY;
    hex_count_next = hex_count;
    code_unit_next = code_unit;
    for (int i = 0; i < 3; i++) held_next[i] = held[i];
    replay_n  = hex_count;
    do_replay = 1'b0;
    do_plain  = 1'b0;

    unique case (mode)
      MODE_ESC: begin
        unique case (in_byte)
          CH_BSLASH, CH_QUOTE, CH_SLASH: b = push(b, in_byte, 1'b0);
          CH_LC_T: b = push(b, CH_TAB, 1'b0);
          CH_LC_R: b = push(b, CH_CR, 1'b0);
          CH_LC_N: b = push(b, CH_LF, 1'b0);
          CH_LC_F: b = push(b, CH_FF, 1'b0);
          CH_LC_B: b = push(b, CH_BS, 1'b0);
          CH_LC_U: begin
            hex_count_next = 2'd0;
            code_unit_next = '0;
            replay_n       = 2'd0;
            if (in_last) do_replay = 1'b1;
            else mode_next = MODE_HEX;
          end
          default: begin
            b = push(b, CH_BSLASH, 1'b0);
            b = push(b, in_byte, 1'b0);
          end
        endcase
      end
      MODE_HEX: begin
        if (is_hex) begin
          code_unit_next = cu;
          if (hex_count == 2'd3) begin
            hex_count_next = 2'd0;
            if (cu[15:11] == 5'b11011) begin
              b = push(b, 8'h00, 1'b1);            // surrogate half
            end else if (cu[15:7] == '0) begin
              b = push(b, cu[7:0], 1'b0);
            end else if (cu[15:11] == '0) begin
              b = push(b, {3'b110, cu[10:6]}, 1'b0);
              b = push(b, {2'b10, cu[5:0]}, 1'b0);
            end else begin
              b = push(b, {4'he, cu[15:12]}, 1'b0);
              b = push(b, {2'b10, cu[11:6]}, 1'b0);
              b = push(b, {2'b10, cu[5:0]}, 1'b0);
            end
          end else begin
            held_next[hex_count] = in_byte;
            hex_count_next       = hex_count + 2'd1;
            if (in_last) begin
              replay_n       = hex_count + 2'd1;
              do_replay      = 1'b1;
              hex_count_next = 2'd0;
            end else begin
              mode_next = MODE_HEX;
            end
          end
        end else begin
          // cut short: replay what was held, then treat byte as plain
          do_replay      = 1'b1;
          do_plain       = 1'b1;
          hex_count_next = 2'd0;
        end
      end
      default: do_plain = 1'b1;
    endcase

    if (do_replay) begin
      b = push(b, CH_BSLASH, 1'b0);
      b = push(b, CH_LC_U, 1'b0);
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < replay_n) b = push(b, held_next[i], 1'b0);
      end
    end

    if (do_plain) begin
      if (in_byte == CH_BSLASH && !in_last) mode_next = MODE_ESC;
      else b = push(b, in_byte, 1'b0);
    end

    if (in_last) begin
      mode_next      = MODE_COPY;
      hex_count_next = 2'd0;
    end
    b.last = in_last;
  end

  assign burst = b;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_COPY;
      hex_count <= 2'd0;
      code_unit <= '0;
    end else if (accept) begin
      mode      <= mode_next;
      hex_count <= hex_count_next;
      code_unit <= code_unit_next;
    end
  end

  // digit bytes only read below hex_count, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) held[i] <= held_next[i];
    end
  end

endmodule

// File: rtl/core/jsu_burst.sv
// Result register: holds one decoded burst and sends it out a beat at a time.
// Depends on jsu_pkg.
module jsu_burst (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  jsu_pkg::burst_t burst,
  output logic            ready,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            surrogate_error
);
  import jsu_pkg::*;

  logic [7:0]      data [MaxBeats];
  logic            err  [MaxBeats];
  logic [CntW-1:0] cnt;
  logic            lst;
  logic            take;

  assign out_valid       = (cnt != '0);
  assign take            = out_valid && !out_stall;
  // free once the last held beat leaves this cycle
  assign ready           = (cnt == '0) || (cnt == CntW'(1) && take);
  assign out_byte        = data[0];
  assign surrogate_error = err[0];
  assign out_last        = lst && (cnt == CntW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= burst.count;
    end else if (take) begin
      cnt <= cnt - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lst <= burst.last;
      for (int i = 0; i < MaxBeats; i++) begin
        data[i] <= burst.bytes[i];
        err[i]  <= burst.err[i];
      end
    end else if (take) begin
      for (int i = 0; i < MaxBeats - 1; i++) begin
        data[i] <= data[i+1];
        err[i]  <= err[i+1];
      end
    end
  end

endmodule

// File: rtl/core/json_string_unescape.sv
// JSON string body unescaper, top level.
// Depends on jsu_pkg, jsu_decode and jsu_burst.
//
// Input channel (in_valid / in_stall): one raw byte of the escaped string per
// beat, in_last on the final byte. Output channel (out_valid / out_stall):
// one unescaped byte per beat; out_last marks the final beat caused by the
// final input byte, surrogate_error flags a \u code unit in D800..DFFF
// (out_byte is then 0).
//
// Latency: a byte is decoded in the cycle it is accepted; its first result
// beat is visible on the output the next cycle.
// Throughput: one input byte per cycle while each byte yields at most one
// beat and out_stall is low. A byte that yields more beats (up to six: a
// cut-short \u replay plus the byte) holds the burst register until they
// have drained; the next byte is taken in the cycle the last beat leaves.
// Bytes that yield no beat (backslash, \u digits) pass at one per cycle.
// When the receiver stalls, the held beat stays put and in_stall rises as
// soon as the burst register has no room for the next byte's results.
// Reset (rst, synchronous) returns to plain copying and empties the burst
// register.
module json_string_unescape (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       surrogate_error
);
  import jsu_pkg::*;

  logic   ready;
  logic   accept;
  burst_t burst;

  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  // parse state and per-byte decode
  jsu_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .burst   (burst)
  );

  // result register, drains one beat per cycle while out_stall is low
  jsu_burst u_burst (
    .clk             (clk),
    .rst             (rst),
    .load            (accept),
    .burst           (burst),
    .ready           (ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .surrogate_error (surrogate_error)
  );

endmodule
